// File: sv/perceptron_online_trainer_macros.svh
// Assertion helpers for the top-level RTL
`ifndef PERCEPTRON_ONLINE_TRAINER_MACROS_SVH
`define PERCEPTRON_ONLINE_TRAINER_MACROS_SVH

// same-cycle implication, disabled in reset
`define POT_ASSERT_IMP(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("assertion failed");

// next-cycle implication, disabled in reset
`define POT_ASSERT_NEXT(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("assertion failed");

`endif

// File: sv/pot_pkg.sv
package pot_pkg;

  // fixed widths
  localparam int FEAT_W         = 16;
  localparam int WEIGHT_W       = 32;
  localparam int ETA_W          = 16;
  localparam int COUNT_W        = 16;
  localparam int PROD_W         = WEIGHT_W + FEAT_W;
  localparam int UPD_W          = ETA_W + 2 + FEAT_W;
  localparam int INPUT_FEATURES = 4;

  localparam logic [COUNT_W-1:0] COUNT_MAX = 16'hFFFF;
  localparam logic [ETA_W-1:0]   LR_RESET  = 16'd6554;

  // request codes; code 3 behaves as classify
  localparam logic [1:0] REQ_TRAIN    = 2'd0;
  localparam logic [1:0] REQ_CLASSIFY = 2'd1;
  localparam logic [1:0] REQ_CLEAR    = 2'd2;

  typedef struct packed {
    logic [1:0]               req_type;
    logic signed [FEAT_W-1:0] feature_0;
    logic signed [FEAT_W-1:0] feature_1;
    logic signed [FEAT_W-1:0] feature_2;
    logic signed [FEAT_W-1:0] feature_3;
    logic                     label_positive;
    logic                     epoch_end;
  } in_t;

  typedef struct packed {
    logic               predicted_positive;
    logic               weights_changed;
    logic [COUNT_W-1:0] epoch_errors;
    logic               epoch_done;
  } out_t;

  // per-item info held between the multiply and merge cycles
  typedef struct packed {
    logic [1:0] req_type;
    logic       label_positive;
    logic       epoch_end;
  } stage_t;

  // weight control sent to lanes and merge
  typedef struct packed {
    logic load;
    logic commit;
    logic clear;
    logic label_pos;
  } lane_ctl_t;

endpackage

// File: sv/pot_lane.sv
module pot_lane (
  input  logic                                 clk,
  input  logic                                 rst,
  input  pot_pkg::lane_ctl_t                   ctl,
  input  logic signed [pot_pkg::FEAT_W-1:0]    feature,
  input  logic [pot_pkg::ETA_W-1:0]            eta,
  output logic signed [pot_pkg::PROD_W-1:0]    product
);
  import pot_pkg::*;

  localparam int STEP_W = UPD_W - 8;

  logic signed [WEIGHT_W-1:0] weight;
  logic signed [WEIGHT_W-1:0] weight_next;
  logic signed [UPD_W-1:0]    upd_prod;
  logic signed [UPD_W-1:0]    upd_signed;
  logic signed [STEP_W-1:0]   step;
  logic signed [WEIGHT_W:0]   weight_sum;

  // multiply on the accept beat: dot-product term and unsigned-rate step term
  always_ff @(posedge clk) begin
    if (ctl.load) begin
      product  <= PROD_W'(weight) * PROD_W'(feature);
      upd_prod <= UPD_W'($signed({1'b0, eta, 1'b0})) * UPD_W'(feature);
    end
  end

  // step = floor(+-2*eta*f / 256), then saturating add
  always_comb begin
    upd_signed  = ctl.label_pos ? upd_prod : -upd_prod;
    step        = STEP_W'(upd_signed >>> 8);
    weight_sum  = (WEIGHT_W+1)'(weight) + (WEIGHT_W+1)'(step);
    weight_next = weight_sum[WEIGHT_W-1:0];
    if (weight_sum[WEIGHT_W] != weight_sum[WEIGHT_W-1]) begin
      weight_next = weight_sum[WEIGHT_W] ? {1'b1, {(WEIGHT_W-1){1'b0}}}
                                         : {1'b0, {(WEIGHT_W-1){1'b1}}};
    end
  end

  // weight register
  always_ff @(posedge clk) begin
    if (rst) begin
      weight <= '0;
    end else if (ctl.clear) begin
      weight <= '0;
    end else if (ctl.commit) begin
      weight <= weight_next;
    end
  end

endmodule

// File: sv/pot_merge.sv
module pot_merge #(
  parameter int NUM_FEATURES = 4
) (
  input  logic                              clk,
  input  logic                              rst,
  input  pot_pkg::lane_ctl_t                ctl,
  input  pot_pkg::stage_t                   stage,
  input  logic [pot_pkg::ETA_W-1:0]         eta,
  input  logic signed [pot_pkg::PROD_W-1:0] products [NUM_FEATURES],
  output logic                              pred,
  output logic                              mistake
);
  import pot_pkg::*;

  localparam int SUM_W = PROD_W + $clog2(NUM_FEATURES + 1);

  logic signed [WEIGHT_W-1:0] bias;
  logic signed [WEIGHT_W-1:0] bias_next;
  logic signed [WEIGHT_W:0]   bias_sum;
  logic signed [ETA_W+1:0]    update;
  logic signed [SUM_W-1:0]    net;

  // net = bias*256 + sum of lane products
  always_comb begin
    net = SUM_W'($signed({bias, 8'b0}));
    for (int i = 0; i < NUM_FEATURES; i++) begin
      net = net + SUM_W'(products[i]);
    end
  end

  assign pred    = (stage.req_type != REQ_CLEAR) && (net > 0);
  assign mistake = (stage.req_type == REQ_TRAIN) && (pred != stage.label_positive);

  // bias moves by +-2*eta with saturation
  always_comb begin
    update    = ctl.label_pos ? $signed({1'b0, eta, 1'b0}) : -$signed({1'b0, eta, 1'b0});
    bias_sum  = (WEIGHT_W+1)'(bias) + (WEIGHT_W+1)'(update);
    bias_next = bias_sum[WEIGHT_W-1:0];
    if (bias_sum[WEIGHT_W] != bias_sum[WEIGHT_W-1]) begin
      bias_next = bias_sum[WEIGHT_W] ? {1'b1, {(WEIGHT_W-1){1'b0}}}
                                     : {1'b0, {(WEIGHT_W-1){1'b1}}};
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      bias <= '0;
    end else if (ctl.clear) begin
      bias <= '0;
    end else if (ctl.commit) begin
      bias <= bias_next;
    end
  end

endmodule

// File: sv/perceptron_online_trainer.sv
// Channel  | Handshake             | Payload
// ---------+-----------------------+-------------------------
// in       | in_valid / in_ready   | in_data  (pot_pkg::in_t)
// out      | out_valid / out_ready | out_data (pot_pkg::out_t)
// cfg      | cfg_wr_en             | cfg_wr_data (learning rate)
//
// Lanes multiply on the accept beat; the merge stage then sums, decides and commits
// weights once out space allows; the weight feedback loop keeps one item in flight.
// A waiting result does not block the next accept; the merge waits for out space.
// Reset (rst, synchronous) zeroes weights, bias and count and loads rate 6554.
module perceptron_online_trainer #(
  parameter int NUM_FEATURES = 4
) (
  input  logic                       clk,
  input  logic                       rst,
  input  logic                       in_valid,
  output logic                       in_ready,
  input  pot_pkg::in_t               in_data,
  output logic                       out_valid,
  input  logic                       out_ready,
  output pot_pkg::out_t              out_data,
  input  logic                       cfg_wr_en,
  input  logic [pot_pkg::ETA_W-1:0]  cfg_wr_data
);
  import pot_pkg::*;
  `include "perceptron_online_trainer_macros.svh"

  logic [ETA_W-1:0]          eta;
  logic                      busy;
  stage_t                    stage;
  lane_ctl_t                 ctl;
  logic                      accept;
  logic                      fire;
  logic                      pred;
  logic                      mistake;
  logic [COUNT_W-1:0]        count;
  logic [COUNT_W-1:0]        count_inc;
  logic [COUNT_W-1:0]        reported;
  logic signed [FEAT_W-1:0]  feat_in   [INPUT_FEATURES];
  logic signed [FEAT_W-1:0]  lane_feat [NUM_FEATURES];
  logic signed [PROD_W-1:0]  products  [NUM_FEATURES];

  // learning rate register
  always_ff @(posedge clk) begin
    if (rst) begin
      eta <= LR_RESET;
    end else if (cfg_wr_en) begin
      eta <= cfg_wr_data;
    end
  end

  // handshake control
  assign in_ready = !busy;
  assign accept   = in_valid && in_ready;
  assign fire     = busy && (!out_valid || out_ready);

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
    end else if (accept) begin
      busy <= 1'b1;
    end else if (fire) begin
      busy <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      stage.req_type       <= in_data.req_type;
      stage.label_positive <= in_data.label_positive;
      stage.epoch_end      <= in_data.epoch_end;
    end
  end

  always_comb begin
    ctl.load      = accept;
    ctl.commit    = fire && mistake;
    ctl.clear     = fire && (stage.req_type == REQ_CLEAR);
    ctl.label_pos = stage.label_positive;
  end

  // feature fan-out; lanes past the input fields see zero
  assign feat_in[0] = in_data.feature_0;
  assign feat_in[1] = in_data.feature_1;
  assign feat_in[2] = in_data.feature_2;
  assign feat_in[3] = in_data.feature_3;

  for (genvar i = 0; i < NUM_FEATURES; i++) begin : g_lane
    if (i < INPUT_FEATURES) begin : g_fed
      assign lane_feat[i] = feat_in[i];
    end else begin : g_zero
      assign lane_feat[i] = '0;
    end

    pot_lane u_lane (
      .clk     (clk),
      .rst     (rst),
      .ctl     (ctl),
      .feature (lane_feat[i]),
      .eta     (eta),
      .product (products[i])
    );
  end

  pot_merge #(
    .NUM_FEATURES (NUM_FEATURES)
  ) u_merge (
    .clk      (clk),
    .rst      (rst),
    .ctl      (ctl),
    .stage    (stage),
    .eta      (eta),
    .products (products),
    .pred     (pred),
    .mistake  (mistake)
  );

  // epoch mistake count
  assign count_inc = (mistake && (count != COUNT_MAX)) ? count + 1'b1 : count;
  assign reported  = (stage.req_type == REQ_CLEAR) ? '0 : count_inc;

  always_ff @(posedge clk) begin
    if (rst) begin
      count <= '0;
    end else if (fire) begin
      count <= stage.epoch_end ? '0 : reported;
    end
  end

  // output register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (fire) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (fire) begin
      out_data.predicted_positive <= pred;
      out_data.weights_changed    <= mistake;
      out_data.epoch_errors       <= reported;
      out_data.epoch_done         <= stage.epoch_end;
    end
  end

  // checks
  `POT_ASSERT_NEXT(a_spacing, clk, rst, accept, !in_ready)
  `POT_ASSERT_NEXT(a_clear_out, clk, rst, fire && (stage.req_type == REQ_CLEAR),
                   (out_data.epoch_errors == '0) && !out_data.weights_changed)
  `POT_ASSERT_NEXT(a_count_up, clk, rst,
                   fire && mistake && !stage.epoch_end && (count != COUNT_MAX),
                   count == $past(count) + 1'b1)

endmodule

// File: test/tb_perceptron_online_trainer.sv
module tb_perceptron_online_trainer;
  timeunit 1ns;
  timeprecision 1ps;

  import pot_pkg::*;

  // request code 3 is unused and behaves as classify
  localparam logic [1:0] REQ_SPARE = 2'd3;
  localparam int QUIET_LIMIT = 2000;
  localparam int PHASE_ITEMS = 150;
  localparam int NUM_DIRECTED = 20;

  typedef struct {
    in_t  beat;
    bit   typed;
    out_t result;
  } directed_row_t;

  logic                 clk = 1'b0;
  logic                 rst = 1'b1;
  logic                 in_valid = 1'b0;
  logic                 in_ready;
  in_t                  in_data = '0;
  logic                 out_valid;
  logic                 out_ready = 1'b0;
  out_t                 out_data;
  logic                 cfg_wr_en = 1'b0;
  logic [ETA_W-1:0]     cfg_wr_data = '0;

  // trainer state as the testbench sees it
  int                   weight_q16 [INPUT_FEATURES];
  int                   bias_q16;
  logic [COUNT_W-1:0]   mistake_count;
  logic [ETA_W-1:0]     learning_rate;

  // hidden separating plane used to label random samples
  int                   plane_w [INPUT_FEATURES];
  int                   plane_bias;

  out_t                 expected_results [$];
  int                   mismatches = 0;
  int                   quiet_cycles = 0;
  bit                   steady = 1'b0;

  directed_row_t        directed_rows [NUM_DIRECTED];

  perceptron_online_trainer u_top (
    .clk        (clk),
    .rst        (rst),
    .in_valid   (in_valid),
    .in_ready   (in_ready),
    .in_data    (in_data),
    .out_valid  (out_valid),
    .out_ready  (out_ready),
    .out_data   (out_data),
    .cfg_wr_en  (cfg_wr_en),
    .cfg_wr_data(cfg_wr_data)
  );

  always #10 clk = ~clk;

  function automatic int clamp_q16(input longint v);
    if (v > 64'sd2147483647) return 32'sh7FFFFFFF;
    if (v < -64'sd2147483648) return 32'sh80000000;
    return int'(v);
  endfunction

  // clear on a clear request; else prediction from current weights, then perceptron update on a mistake
  function automatic out_t classify_and_learn(input in_t s);
    out_t   r;
    longint feat [INPUT_FEATURES];
    longint net;
    longint upd;
    logic   pos;
    feat[0] = longint'($signed(s.feature_0));
    feat[1] = longint'($signed(s.feature_1));
    feat[2] = longint'($signed(s.feature_2));
    feat[3] = longint'($signed(s.feature_3));
    r = '0;
    if (s.req_type == REQ_CLEAR) begin
      foreach (weight_q16[i]) weight_q16[i] = 0;
      bias_q16 = 0;
      mistake_count = '0;
    end else begin
      net = longint'(bias_q16) * 256;
      foreach (weight_q16[i]) net += longint'(weight_q16[i]) * feat[i];
      pos = (net > 0);
      r.predicted_positive = pos;
      if (s.req_type == REQ_TRAIN && pos != s.label_positive) begin
        // update = eta * (label - prediction) = +-2*eta
        upd = longint'(learning_rate) * 2;
        if (!s.label_positive) upd = -upd;
        foreach (weight_q16[i])
          weight_q16[i] = clamp_q16(longint'(weight_q16[i]) + ((upd * feat[i]) >>> 8));
        bias_q16 = clamp_q16(longint'(bias_q16) + upd);
        r.weights_changed = 1'b1;
        if (mistake_count != COUNT_MAX) mistake_count = mistake_count + 1'b1;
      end
    end
    // count is reported first, then cleared at epoch end
    r.epoch_errors = mistake_count;
    r.epoch_done = s.epoch_end;
    if (s.epoch_end) mistake_count = '0;
    return r;
  endfunction

  function automatic directed_row_t row(input logic [1:0] req, input int f0, input int f1,
                                        input int f2, input int f3, input bit lab,
                                        input bit ep, input bit typed = 1'b0,
                                        input bit pred = 1'b0, input bit chg = 1'b0,
                                        input int errs = 0);
    directed_row_t r;
    r.beat.req_type = req;
    r.beat.feature_0 = f0[FEAT_W-1:0];
    r.beat.feature_1 = f1[FEAT_W-1:0];
    r.beat.feature_2 = f2[FEAT_W-1:0];
    r.beat.feature_3 = f3[FEAT_W-1:0];
    r.beat.label_positive = lab;
    r.beat.epoch_end = ep;
    r.typed = typed;
    r.result.predicted_positive = pred;
    r.result.weights_changed = chg;
    r.result.epoch_errors = errs[COUNT_W-1:0];
    r.result.epoch_done = ep;
    return r;
  endfunction

  // mix of corner values, small Q8.8 values and full-range words
  function automatic logic [FEAT_W-1:0] draw_feature();
    int pick;
    pick = $urandom_range(99);
    if (pick < 10) begin
      case ($urandom_range(4))
        0: return 16'h8000;
        1: return 16'h7FFF;
        2: return 16'h0000;
        3: return 16'hFFFF;
        default: return 16'h0001;
      endcase
    end
    if (pick < 50) return FEAT_W'(int'($urandom_range(2047)) - 1024);
    return FEAT_W'($urandom);
  endfunction

  function automatic in_t draw_sample();
    in_t    s;
    int     pick;
    longint score;
    pick = $urandom_range(99);
    if (pick < 72) s.req_type = REQ_TRAIN;
    else if (pick < 88) s.req_type = REQ_CLASSIFY;
    else if (pick < 97) s.req_type = REQ_SPARE;
    else s.req_type = REQ_CLEAR;
    s.feature_0 = draw_feature();
    s.feature_1 = draw_feature();
    s.feature_2 = draw_feature();
    s.feature_3 = draw_feature();
    score = longint'(plane_bias) * 256
          + longint'(plane_w[0]) * longint'($signed(s.feature_0))
          + longint'(plane_w[1]) * longint'($signed(s.feature_1))
          + longint'(plane_w[2]) * longint'($signed(s.feature_2))
          + longint'(plane_w[3]) * longint'($signed(s.feature_3));
    // mostly consistent labels so training converges; some label noise
    if ($urandom_range(9) == 0) s.label_positive = 1'($urandom_range(1));
    else s.label_positive = (score > 0);
    s.epoch_end = ($urandom_range(24) == 0);
    return s;
  endfunction

  // one input beat; returns right after the accepting edge
  task automatic drive_sample(input in_t d);
    while (!steady && $urandom_range(99) < 18) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid <= 1'b1;
    in_data <= d;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
  endtask

  // rate write only once the trainer has drained
  task automatic set_learning_rate(input logic [ETA_W-1:0] rate);
    in_valid <= 1'b0;
    while (expected_results.size() != 0) @(posedge clk);
    repeat (4) @(posedge clk);
    cfg_wr_en <= 1'b1;
    cfg_wr_data <= rate;
    @(posedge clk);
    cfg_wr_en <= 1'b0;
    learning_rate = rate;
  endtask

  task automatic compare_field(input string name, input int want, input int got);
    if (want != got) begin
      $error("%s: expected %0d, got %0d", name, want, got);
      mismatches++;
    end
  endtask

  // append one expected result beat
  task automatic queue_result(input out_t r);
    expected_results = {expected_results, r};
  endtask

  // output back-pressure
  always @(posedge clk) begin
    out_ready <= steady || ($urandom_range(99) >= 18);
  end

  // result checker
  always @(posedge clk) begin
    out_t want;
    if (!rst && out_valid && out_ready) begin
      if (expected_results.size() == 0) begin
        $error("unexpected result beat: %p", out_data);
        mismatches++;
      end else begin
        want = expected_results.pop_front();
        compare_field("predicted_positive", want.predicted_positive,
                      out_data.predicted_positive);
        compare_field("weights_changed", want.weights_changed, out_data.weights_changed);
        compare_field("epoch_errors", want.epoch_errors, out_data.epoch_errors);
        compare_field("epoch_done", want.epoch_done, out_data.epoch_done);
      end
    end
  end

  // watchdog on cycles with no beat on either channel
  always @(posedge clk) begin
    if ((in_valid && in_ready) || (out_valid && out_ready)) quiet_cycles <= 0;
    else quiet_cycles <= quiet_cycles + 1;
    if (quiet_cycles == QUIET_LIMIT) begin
      $display("perceptron_online_trainer regression: fail");
      $finish;
    end
  end

  initial begin
    logic [ETA_W-1:0] rates [5];
    out_t             predicted;
    in_t              s;

    foreach (weight_q16[i]) weight_q16[i] = 0;
    bias_q16 = 0;
    mistake_count = '0;
    learning_rate = LR_RESET;

    // weights are zero at the start and after a clear, so rows there are typed in directly
    directed_rows = '{
      row(REQ_CLASSIFY, 0, 0, 0, 0, 0, 0, 1, 0, 0, 0),
      row(REQ_TRAIN, 32767, -32768, 1, -1, 1, 0, 1, 0, 1, 1),
      row(REQ_TRAIN, 32767, -32768, 1, -1, 1, 0),
      row(REQ_TRAIN, -32768, 32767, -1, 1, 0, 0),
      row(REQ_CLASSIFY, 32767, 32767, 32767, 32767, 1, 0),
      row(REQ_CLASSIFY, -32768, -32768, -32768, -32768, 0, 0),
      row(REQ_SPARE, 256, -256, 512, 0, 0, 0),
      row(REQ_TRAIN, 0, 0, 0, 0, 0, 1),
      row(REQ_TRAIN, 32767, 32767, -32768, -32768, 1, 1),
      row(REQ_CLEAR, 1234, -1234, 32767, -32768, 1, 0, 1, 0, 0, 0),
      row(REQ_CLASSIFY, 32767, 32767, 32767, 32767, 1, 0, 1, 0, 0, 0),
      row(REQ_TRAIN, 500, 600, 700, 800, 0, 0, 1, 0, 0, 0),
      row(REQ_TRAIN, -32768, -32768, -32768, -32768, 1, 0, 1, 0, 1, 1),
      row(REQ_CLEAR, 0, 0, 0, 0, 0, 1, 1, 0, 0, 0),
      row(REQ_TRAIN, 100, 200, -300, 400, 1, 0, 1, 0, 1, 1),
      row(REQ_TRAIN, 100, 200, -300, 400, 1, 0),
      row(REQ_TRAIN, -1, -1, -1, -1, 0, 0),
      row(REQ_CLASSIFY, 1, 0, 0, 0, 0, 1),
      row(REQ_TRAIN, 32767, 0, 0, 0, 1, 1),
      row(REQ_SPARE, -32768, 32767, -1, 1, 1, 1)
    };

    repeat (10) @(posedge clk);
    rst <= 1'b0;

    // directed rows at the reset learning rate
    foreach (directed_rows[k]) begin
      drive_sample(directed_rows[k].beat);
      predicted = classify_and_learn(directed_rows[k].beat);
      if (directed_rows[k].typed) queue_result(directed_rows[k].result);
      else queue_result(predicted);
    end

    // random phases: smallest nonzero rate, largest rate, zero rate, random, reset value
    rates = '{16'd1, 16'hFFFF, 16'd0, ETA_W'($urandom_range(65535, 1)), LR_RESET};
    foreach (rates[p]) begin
      set_learning_rate(rates[p]);
      foreach (plane_w[i]) plane_w[i] = int'($urandom_range(2000)) - 1000;
      plane_bias = int'($urandom_range(2000)) - 1000;
      for (int n = 0; n < PHASE_ITEMS; n++) begin
        // long stretch with no idling on either side
        steady = (p == 3 && n < 100);
        s = draw_sample();
        drive_sample(s);
        queue_result(classify_and_learn(s));
      end
      steady = 1'b0;
    end

    in_valid <= 1'b0;
    while (expected_results.size() != 0) @(posedge clk);
    repeat (8) @(posedge clk);
    if (mismatches == 0) begin
      $display("perceptron_online_trainer regression: pass");
    end else begin
      $display("perceptron_online_trainer regression: fail");
    end
    $finish;
  end

endmodule
